[design/tasd_pkg.sv]
`timescale 1ns / 1ps
package tasd_pkg;

  localparam int unsigned MAX_SEQ  = 65536;
  localparam int unsigned STOP_MAX = 4;
  localparam int unsigned HIST     = 4;

  localparam int unsigned TOKEN_W = 32;
  localparam int unsigned LEN_W   = 17;
  localparam int unsigned POS_W   = 16;
  localparam int unsigned STOP_W  = 20;
  localparam int unsigned CFG_W   = 21;

  // configuration register indexes
  localparam logic [2:0] CFG_VOCAB_LIM  = 3'd0;
  localparam logic [2:0] CFG_MAX_TOKENS = 3'd1;
  localparam logic [2:0] CFG_EOS_TOKEN  = 3'd2;
  localparam logic [2:0] CFG_STOP_LEN   = 3'd3;
  localparam logic [2:0] CFG_STOP_TOK0  = 3'd4;
  localparam logic [2:0] CFG_STOP_TOK1  = 3'd5;
  localparam logic [2:0] CFG_STOP_TOK2  = 3'd6;
  localparam logic [2:0] CFG_STOP_TOK3  = 3'd7;

  typedef struct packed {
    logic [20:0]                   vocab_lim;
    logic [16:0]                   max_tokens;
    logic [20:0]                   eos_token;
    logic [2:0]                    stop_len;
    logic [HIST-1:0][STOP_W-1:0]   stop_tok;
  } cfg_t;

  typedef struct packed {
    logic [LEN_W-1:0]              seq_len;
    logic [HIST-1:0][TOKEN_W-1:0]  recent;   // entry 0 newest
    logic                          generating;
  } hist_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    logic             first_generated;
    logic             stop_hit;
    logic             eos_hit;
    logic             length_limited;
    logic             bad_token;
    logic             written;
    logic [POS_W-1:0] position;
  } result_t;

endpackage

[design/tasd_eval.sv]
`timescale 1ns / 1ps
module tasd_eval
  import tasd_pkg::*;
(
  input  logic [TOKEN_W-1:0] token_i,
  input  logic               prompt_i,
  input  logic               restart_i,
  input  cfg_t               cfg_i,
  input  hist_t              hist_i,
  output hist_t              hist_o,
  output result_t            result_o
);

  hist_t            cur;
  logic [LEN_W-1:0] limit;
  logic             wr;
  logic             bad;
  logic             limited;
  logic             first;
  logic [2:0]       n;
  logic             stop_ok;
  logic [1:0]       sidx;

  always_comb begin
    cur = restart_i ? '0 : hist_i;
    limit = (cfg_i.max_tokens > LEN_W'(MAX_SEQ)) ? LEN_W'(MAX_SEQ) : cfg_i.max_tokens;
    wr = 1'b0;
    bad = 1'b0;
    limited = 1'b0;
    first = 1'b0;
    hist_o = cur;

    if (prompt_i) begin
      if (cur.seq_len >= LEN_W'(MAX_SEQ)) begin
        limited = 1'b1;
      end else begin
        wr = 1'b1;
      end
    end else begin
      if (cur.seq_len >= limit) begin
        limited = 1'b1;
      end else if (token_i >= {{(TOKEN_W-CFG_W){1'b0}}, cfg_i.vocab_lim}) begin
        // negative tokens are huge unsigned, so this also rejects them
        bad = 1'b1;
      end else begin
        wr = 1'b1;
        first = !cur.generating;
        hist_o.generating = 1'b1;
      end
    end

    if (wr) begin
      hist_o.recent  = {cur.recent[HIST-2:0], token_i};
      hist_o.seq_len = cur.seq_len + LEN_W'(1);
    end

    // stop sequence on the updated history
    n = (cfg_i.stop_len > 3'(STOP_MAX)) ? 3'(STOP_MAX) : cfg_i.stop_len;
    stop_ok = (n != 3'd0) && (hist_o.seq_len >= LEN_W'(n));
    sidx = '0;
    for (int k = 0; k < HIST; k++) begin
      sidx = 2'(n - 3'(k) - 3'd1);
      if ((3'(k) < n) &&
          (hist_o.recent[k] != {{(TOKEN_W-STOP_W){1'b0}}, cfg_i.stop_tok[sidx]})) begin
        stop_ok = 1'b0;
      end
    end

    result_o.position        = wr ? cur.seq_len[POS_W-1:0] : '0;
    result_o.written         = wr;
    result_o.bad_token       = bad;
    result_o.length_limited  = limited;
    result_o.eos_hit         = !cfg_i.eos_token[CFG_W-1] && (hist_o.seq_len != '0) &&
                               (hist_o.recent[0] ==
                                {{(TOKEN_W-CFG_W){1'b0}}, cfg_i.eos_token});
    result_o.stop_hit        = stop_ok;
    result_o.first_generated = first;
    result_o.length          = hist_o.seq_len;
  end

endmodule

[design/token_append_stop_detect_core.sv]
`timescale 1ns / 1ps
// Token history with end-token and stop-sequence detection. Each request carries
// one token (tdata) plus prompt/restart flags (tuser) and gives exactly one result.
// One request is taken every cycle while the input side is not stalled; it passes
// through the input register, then the result register, and the append, range
// check and four-way stop compare all sit between those two registers. Backpressure
// on the result side stalls the input side only once both registers are full.
// Configuration writes must only be made while no request is in flight.
module token_append_stop_detect_core
  import tasd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [20:0] cfg_data_i,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // token
  input  logic [1:0]  s_axis_tuser,   // prompt, restart

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // position[15:0], written, bad_token, length_limited, eos_hit, stop_hit,
  // first_generated, length[16:0], zero pad
  output logic [39:0] m_axis_tdata
);

  cfg_t               cfg_q;
  hist_t              hist_q, hist_d;
  result_t            res_d, res_q;

  logic               in_valid_q;
  logic [TOKEN_W-1:0] in_token_q;
  logic               in_prompt_q;
  logic               in_restart_q;
  logic               out_valid_q;
  logic               advance;
  logic               s_accept;

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vocab_lim  <= 21'd32000;
      cfg_q.max_tokens <= 17'd4096;
      cfg_q.eos_token  <= '1;
      cfg_q.stop_len   <= '0;
      cfg_q.stop_tok   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_VOCAB_LIM:  cfg_q.vocab_lim   <= cfg_data_i;
        CFG_MAX_TOKENS: cfg_q.max_tokens  <= cfg_data_i[16:0];
        CFG_EOS_TOKEN:  cfg_q.eos_token   <= cfg_data_i;
        CFG_STOP_LEN:   cfg_q.stop_len    <= cfg_data_i[2:0];
        CFG_STOP_TOK0:  cfg_q.stop_tok[0] <= cfg_data_i[STOP_W-1:0];
        CFG_STOP_TOK1:  cfg_q.stop_tok[1] <= cfg_data_i[STOP_W-1:0];
        CFG_STOP_TOK2:  cfg_q.stop_tok[2] <= cfg_data_i[STOP_W-1:0];
        CFG_STOP_TOK3:  cfg_q.stop_tok[3] <= cfg_data_i[STOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_token_q   <= s_axis_tdata;
      in_prompt_q  <= s_axis_tuser[0];
      in_restart_q <= s_axis_tuser[1];
    end
  end

  tasd_eval u_eval (
    .token_i   (in_token_q),
    .prompt_i  (in_prompt_q),
    .restart_i (in_restart_q),
    .cfg_i     (cfg_q),
    .hist_i    (hist_q),
    .hist_o    (hist_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        hist_q      <= hist_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q};

`ifndef ASSERT_OFF
  a_written_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.written |-> res_q.length == LEN_W'(res_q.position) + LEN_W'(1))
    else $error("written result length does not follow position");

  a_outcome : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> $onehot0({res_q.written, res_q.bad_token, res_q.length_limited}))
    else $error("more than one outcome flagged");

  a_hit_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.eos_hit || res_q.stop_hit) |-> res_q.length != '0)
    else $error("detection on empty history");

  a_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.first_generated |-> res_q.written && hist_q.generating)
    else $error("first_generated without append");
`endif

endmodule
